// ----- rtl/core/fsps_pkg.sv -----
package fsps_pkg;

    localparam int MaxNodes   = 1024;
    localparam int MinArcConf = 410;
    localparam int TieBand    = 26;

    localparam logic [9:0]  NodeLast = 10'(MaxNodes - 1);
    localparam logic signed [25:0] ScoreMax = 26'sd8388607;
    localparam logic signed [25:0] ScoreMin = -26'sd8388608;

    localparam logic [2:0] REG_CONTEXT_W     = 3'd0;
    localparam logic [2:0] REG_HOOK_W        = 3'd1;
    localparam logic [2:0] REG_DEVELOPMENT_W = 3'd2;
    localparam logic [2:0] REG_RESOLUTION_W  = 3'd3;
    localparam logic [2:0] REG_TARGET_GAIN   = 3'd4;
    localparam logic [2:0] REG_DEFECT_GAIN   = 3'd5;
    localparam logic [2:0] REG_MIN_SPAN      = 3'd6;
    localparam logic [2:0] REG_MAX_SPAN      = 3'd7;

    typedef enum logic [1:0] {
        DIV_PEN  = 2'd0,
        DIV_EMI  = 2'd1,
        DIV_CONF = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     in_load;
        logic     mul_step;
        logic     div_start;
        div_sel_t div_sel;
        logic     pen_load;
        logic     em_load;
        logic     vit_step;
        logic     commit;
        logic     conf_load;
        logic     best_update;
        logic     out_load;
        logic [2:0] step;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

    function automatic logic signed [10:0] trans_q10(input logic [1:0] p, input logic [1:0] s);
        logic signed [10:0] v;
        case ({p, s})
            4'b00_00: v = 11'sd20;
            4'b00_01: v = 11'sd225;
            4'b00_10: v = -11'sd41;
            4'b01_01: v = 11'sd20;
            4'b01_10: v = 11'sd246;
            4'b10_10: v = 11'sd123;
            4'b10_11: v = 11'sd358;
            4'b11_11: v = -11'sd102;
            default:  v = -11'sd563;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/fsps_div.sv -----
module fsps_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [14:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [16:0] den_reg;
    logic [14:0] q_reg, q_next;
    logic [2:0]  cnt_reg;
    logic        busy_reg, done_reg;

    always_comb begin
        logic [47:0] r;
        logic [47:0] dsh;
        logic [3:0]  sh;
        logic [2:0]  qb;
        r  = {16'b0, rem_reg};
        qb = 3'b0;
        for (int j = 0; j < 3; j++) begin
            sh  = 4'(3 * cnt_reg) + 4'(2 - j);
            dsh = {31'b0, den_reg} << sh;
            if (r >= dsh) begin
                r         = r - dsh;
                qb[2 - j] = 1'b1;
            end
        end
        rem_next = r[31:0];
        q_next   = {q_reg[11:0], qb};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= dividend;
                den_reg  <= divisor;
                q_reg    <= 15'd0;
                cnt_reg  <= 3'd4;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/core/fsps_dp.sv -----
module fsps_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    input  logic [2:0]     cfg_index,
    input  logic [23:0]    cfg_data,
    input  logic [119:0]   s_tdata,
    input  logic           s_tuser,
    input  fsps_pkg::cmd_t cmd,
    output fsps_pkg::stat_t stat,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,
    output logic           m_tuser
);

    logic [12:0] w_reg [4];
    logic [11:0] tg_reg;
    logic [12:0] dg_reg;
    logic [23:0] min_reg, max_reg;

    logic [10:0] lvl_reg [6];
    logic [23:0] start_reg, end_reg;
    logic [23:0] prod_reg [6];
    logic [9:0]  pen_reg;
    logic signed [15:0] em_reg [4];

    logic signed [23:0] score_reg [4];
    logic signed [23:0] nscore_reg [4];
    logic [9:0]  first_reg [4], nfirst_reg [4];
    logic [23:0] fstart_reg [4], nfstart_reg [4];
    logic [2:0]  flags_reg [4], nflags_reg [4];
    logic [9:0]  node_reg, idx_reg;
    logic [23:0] prev_end_reg;

    logic        best_valid_reg;
    logic [9:0]  best_first_reg, best_last_reg;
    logic [10:0] best_conf_reg, conf_reg;
    logic [23:0] best_start_reg;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic [10:0] lvl_sel;
    logic [12:0] w_sel;
    logic [23:0] mul_res;
    logic signed [33:0] num_sel;
    logic        em_neg;
    logic [31:0] em_mag;
    logic [23:0] gap;
    logic [13:0] gap_c;
    logic [31:0] pen_dividend;
    logic [10:0] nodes;
    logic        score_pos, conf_cap;
    logic [31:0] conf_dividend;
    logic        div_start;
    logic [31:0] div_dividend;
    logic [16:0] div_divisor;
    logic        div_done;
    logic [14:0] div_q;
    logic [1:0]  s_idx;
    logic signed [23:0] v_score;
    logic [9:0]  v_first;
    logic [23:0] v_start;
    logic [2:0]  v_flags, own;
    logic signed [24:0] dur;
    logic        span_ok, arc_ok, take;
    logic signed [11:0] diff;

    assign s_idx = cmd.step[1:0];

    always_comb begin
        case (cmd.step)
            3'd0: begin lvl_sel = lvl_reg[0]; w_sel = w_reg[0]; end
            3'd1: begin lvl_sel = lvl_reg[1]; w_sel = w_reg[1]; end
            3'd2: begin lvl_sel = lvl_reg[2]; w_sel = w_reg[2]; end
            3'd3: begin lvl_sel = lvl_reg[3]; w_sel = w_reg[3]; end
            3'd4: begin
                lvl_sel = lvl_reg[4];
                w_sel = (tg_reg < 12'd256) ? 13'd256 :
                        (tg_reg > 12'd3072) ? 13'd3072 : {1'b0, tg_reg};
            end
            3'd5: begin
                lvl_sel = lvl_reg[5];
                w_sel = (dg_reg < 13'd256) ? 13'd256 :
                        (dg_reg > 13'd4096) ? 13'd4096 : dg_reg;
            end
            default: begin lvl_sel = 11'd0; w_sel = 13'd0; end
        endcase
        mul_res = 24'(lvl_sel * w_sel);
    end

    always_comb begin
        logic signed [33:0] fc, fh, fd, fr, t, d;
        fc = $signed({10'b0, prod_reg[0]});
        fh = $signed({10'b0, prod_reg[1]});
        fd = $signed({10'b0, prod_reg[2]});
        fr = $signed({10'b0, prod_reg[3]});
        t  = $signed({10'b0, prod_reg[4]});
        d  = $signed({10'b0, prod_reg[5]});
        case (s_idx)
            2'd0:    num_sel = 34'sd76 * fc + 34'sd12 * t - 34'sd52 * d;
            2'd1:    num_sel = 34'sd74 * fh + 34'sd18 * fc + 34'sd18 * t - 34'sd48 * d;
            2'd2:    num_sel = 34'sd60 * fd + 34'sd24 * t + 34'sd8 * fh - 34'sd34 * d;
            default: num_sel = 34'sd72 * fr + 34'sd14 * fd + 34'sd10 * t - 34'sd40 * d;
        endcase
        em_neg = num_sel[33];
        em_mag = em_neg ? 32'(34'sd102399 - num_sel) : 32'(num_sel);
    end

    always_comb begin
        gap          = (start_reg > prev_end_reg) ? start_reg - prev_end_reg : 24'd0;
        gap_c        = (gap > 24'd12600) ? 14'd12600 : gap[13:0];
        pen_dividend = {6'b0, gap_c, 12'b0} + {7'b0, gap_c, 11'b0};
        nodes        = {1'b0, idx_reg} - {1'b0, first_reg[3]} + 11'd1;
        score_pos    = (score_reg[3] > 24'sd0);
        conf_dividend = score_pos ? {8'b0, score_reg[3]} : 32'd0;
        conf_cap     = (conf_dividend >= ({11'b0, nodes, 10'b0} + {21'b0, nodes}));
        div_start    = cmd.div_start;
        case (cmd.div_sel)
            fsps_pkg::DIV_PEN:  begin div_dividend = pen_dividend;  div_divisor = 17'd100000; end
            fsps_pkg::DIV_EMI:  begin div_dividend = em_mag;        div_divisor = 17'd102400; end
            fsps_pkg::DIV_CONF: begin div_dividend = conf_dividend; div_divisor = {6'b0, nodes}; end
            default:            begin div_dividend = 32'd0;         div_divisor = 17'd1; end
        endcase
    end

    fsps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        logic signed [25:0] sum;
        logic signed [23:0] cand;
        case (s_idx)
            2'd0:    own = (lvl_reg[0] >= 11'd431) ? 3'b001 : 3'b000;
            2'd1:    own = (lvl_reg[1] >= 11'd431) ? 3'b010 : 3'b000;
            2'd2:    own = (lvl_reg[2] >= 11'd349) ? 3'b100 : 3'b000;
            default: own = 3'b000;
        endcase
        v_score = 24'(em_reg[s_idx]);
        v_first = node_reg;
        v_start = start_reg;
        v_flags = own;
        if (node_reg != 10'd0) begin
            for (int p = 0; p < 4; p++) begin
                sum = 26'(score_reg[p]) + 26'(em_reg[s_idx])
                    + 26'(fsps_pkg::trans_q10(2'(p), s_idx))
                    - $signed({16'b0, pen_reg});
                cand = (sum > fsps_pkg::ScoreMax) ? 24'sd8388607 :
                       (sum < fsps_pkg::ScoreMin) ? -24'sd8388608 : 24'(sum);
                if (cand > v_score) begin
                    v_score = cand;
                    v_first = first_reg[p];
                    v_start = fstart_reg[p];
                    v_flags = flags_reg[p] | own;
                end
            end
        end
    end

    always_comb begin
        dur     = $signed({1'b0, end_reg}) - $signed({1'b0, fstart_reg[3]});
        span_ok = (dur >= $signed({1'b0, min_reg})) && (dur <= $signed({1'b0, max_reg}));
        arc_ok  = (flags_reg[3][1:0] != 2'b00) && flags_reg[3][2];
        diff    = $signed({1'b0, conf_reg}) - $signed({1'b0, best_conf_reg});
        take    = span_ok && arc_ok && (conf_reg >= 11'(fsps_pkg::MinArcConf)) &&
                  (!best_valid_reg || (diff >= 12'(fsps_pkg::TieBand)) ||
                   ((diff > -12'sd26) && (diff < 12'(fsps_pkg::TieBand)) &&
                    (fstart_reg[3] < best_start_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                w_reg[i] <= 13'd1024;
            end
            tg_reg  <= 12'd1024;
            dg_reg  <= 13'd1024;
            min_reg <= 24'd15000;
            max_reg <= 24'd90000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                fsps_pkg::REG_CONTEXT_W:     w_reg[0] <= cfg_data[12:0];
                fsps_pkg::REG_HOOK_W:        w_reg[1] <= cfg_data[12:0];
                fsps_pkg::REG_DEVELOPMENT_W: w_reg[2] <= cfg_data[12:0];
                fsps_pkg::REG_RESOLUTION_W:  w_reg[3] <= cfg_data[12:0];
                fsps_pkg::REG_TARGET_GAIN:   tg_reg   <= cfg_data[11:0];
                fsps_pkg::REG_DEFECT_GAIN:   dg_reg   <= cfg_data[12:0];
                fsps_pkg::REG_MIN_SPAN:      min_reg  <= cfg_data;
                fsps_pkg::REG_MAX_SPAN:      max_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            for (int i = 0; i < 6; i++) begin
                lvl_reg[i] <= s_tdata[11 * i +: 11];
            end
            start_reg <= s_tdata[89:66];
            end_reg   <= s_tdata[113:90];
        end
        if (cmd.mul_step) begin
            prod_reg[cmd.step] <= mul_res;
        end
        if (cmd.pen_load) begin
            pen_reg <= (gap > 24'd4000) ?
                       ((div_q > 15'd768) ? 10'd768 : div_q[9:0]) : 10'd0;
        end
        if (cmd.em_load) begin
            em_reg[s_idx] <= em_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        end
        if (cmd.vit_step) begin
            nscore_reg[s_idx]  <= v_score;
            nfirst_reg[s_idx]  <= v_first;
            nfstart_reg[s_idx] <= v_start;
            nflags_reg[s_idx]  <= v_flags;
        end
        if (cmd.conf_load) begin
            conf_reg <= !score_pos ? 11'd0 : conf_cap ? 11'd1024 : div_q[10:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.in_load && s_tuser)) begin
            for (int i = 0; i < 4; i++) begin
                score_reg[i]  <= 24'sd0;
                first_reg[i]  <= 10'd0;
                fstart_reg[i] <= 24'd0;
                flags_reg[i]  <= 3'd0;
            end
            node_reg       <= 10'd0;
            idx_reg        <= 10'd0;
            prev_end_reg   <= 24'd0;
            best_valid_reg <= 1'b0;
            best_first_reg <= 10'd0;
            best_last_reg  <= 10'd0;
            best_conf_reg  <= 11'd0;
            best_start_reg <= 24'd0;
        end else begin
            if (cmd.commit) begin
                for (int i = 0; i < 4; i++) begin
                    score_reg[i]  <= nscore_reg[i];
                    first_reg[i]  <= nfirst_reg[i];
                    fstart_reg[i] <= nfstart_reg[i];
                    flags_reg[i]  <= nflags_reg[i];
                end
                prev_end_reg <= end_reg;
                idx_reg      <= node_reg;
                if (node_reg < fsps_pkg::NodeLast) begin
                    node_reg <= node_reg + 10'd1;
                end
            end
            if (cmd.best_update && take) begin
                best_valid_reg <= 1'b1;
                best_first_reg <= first_reg[3];
                best_last_reg  <= idx_reg;
                best_conf_reg  <= conf_reg;
                best_start_reg <= fstart_reg[3];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tuser_reg <= best_valid_reg;
            m_tdata_reg <= best_valid_reg ?
                           {1'b0, best_conf_reg, best_last_reg, best_first_reg} : 32'd0;
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;

endmodule

// ----- rtl/core/fsps_ctrl.sv -----
module fsps_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output fsps_pkg::cmd_t  cmd,
    input  fsps_pkg::stat_t stat
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_MUL    = 12'b0000_0000_0010,
        ST_PEN    = 12'b0000_0000_0100,
        ST_PWAIT  = 12'b0000_0000_1000,
        ST_EMI    = 12'b0000_0001_0000,
        ST_EWAIT  = 12'b0000_0010_0000,
        ST_VIT    = 12'b0000_0100_0000,
        ST_COMMIT = 12'b0000_1000_0000,
        ST_CONF   = 12'b0001_0000_0000,
        ST_CWAIT  = 12'b0010_0000_0000,
        ST_BEST   = 12'b0100_0000_0000,
        ST_HOLD   = 12'b1000_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;

    always_comb begin
        cmd        = '0;
        cmd.step   = step_reg;
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_MUL;
                    step_next   = 3'd0;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (step_reg == 3'd5) begin
                    state_next = ST_PEN;
                    step_next  = 3'd0;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_PEN: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = fsps_pkg::DIV_PEN;
                state_next    = ST_PWAIT;
            end
            ST_PWAIT: begin
                if (stat.div_done) begin
                    cmd.pen_load = 1'b1;
                    state_next   = ST_EMI;
                    step_next    = 3'd0;
                end
            end
            ST_EMI: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = fsps_pkg::DIV_EMI;
                state_next    = ST_EWAIT;
            end
            ST_EWAIT: begin
                if (stat.div_done) begin
                    cmd.em_load = 1'b1;
                    if (step_reg == 3'd3) begin
                        state_next = ST_VIT;
                        step_next  = 3'd0;
                    end else begin
                        state_next = ST_EMI;
                        step_next  = step_reg + 3'd1;
                    end
                end
            end
            ST_VIT: begin
                cmd.vit_step = 1'b1;
                if (step_reg == 3'd3) begin
                    state_next = ST_COMMIT;
                    step_next  = 3'd0;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_CONF;
            end
            ST_CONF: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = fsps_pkg::DIV_CONF;
                state_next    = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (stat.div_done) begin
                    cmd.conf_load = 1'b1;
                    state_next    = ST_BEST;
                end
            end
            ST_BEST: begin
                cmd.best_update = 1'b1;
                state_next      = ST_HOLD;
            end
            ST_HOLD: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ----- rtl/core/four_state_arc_path_scorer.sv -----
// Scores one transcript segment per input beat with a four-state max-sum
// search (context, hook, development, resolution) and returns one result beat
// per segment giving the best accepted span so far. From acceptance to
// result, a segment goes through six feature products on one shared
// multiplier, then six divisions (gap penalty, four emissions, confidence) on
// one shared divider that retires three quotient bits a cycle, plus the
// per-state path update. A finished result waits in the output register while
// the next segment is taken. Set s_tuser high on the first segment of a search
// to clear all path state. Write configuration only while no segment is in
// flight.
module four_state_arc_path_scorer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // context_level, hook_level, development_level, resolution_level,
    // target_level, defect_level, start_ms, end_ms, zero pad
    input  logic [119:0] s_tdata,
    // new_run
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // first_index, last_index, confidence, zero pad
    output logic [31:0]  m_tdata,
    // found
    output logic         m_tuser
);

    fsps_pkg::cmd_t  cmd;
    fsps_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    fsps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fsps_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- rtl/core/fsps_chk.sv -----
module fsps_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("segment taken while another is in flight");

    a_no_result_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 !$rose(m_tvalid))
        else $error("result beat too soon after segment");

    a_empty_when_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("result fields set without a found span");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind four_state_arc_path_scorer fsps_chk u_fsps_chk (.*);
